### rtl/core/dhc_pkg.sv
// Shared constants and types for the difference-image hash compare core.
// No dependencies; compile before the interfaces and the core.
package dhc_pkg;

   // Default hash side (hash is HASH_SIDE x HASH_SIDE bits)
   localparam int HASH_SIDE_DEFAULT = 8;

   // Field widths
   localparam int CHANNEL_WIDTH = 16;
   localparam int LUMA_WIDTH    = 24;
   localparam int COUNT_WIDTH   = 7;

   typedef logic [CHANNEL_WIDTH-1:0] channel_type;
   typedef logic [LUMA_WIDTH-1:0]    luma_type;
   typedef logic [COUNT_WIDTH-1:0]   count_type;

   // Luma weights, unsigned fixed point with 8 fraction bits (0.21, 0.72, 0.07)
   localparam luma_type WEIGHT_RED   = luma_type'(54);
   localparam luma_type WEIGHT_GREEN = luma_type'(184);
   localparam luma_type WEIGHT_BLUE  = luma_type'(18);

   // Mismatch counter saturates here
   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

### rtl/core/dhc_channels.sv
// Valid/ready channel interfaces for the difference-image hash compare core.
// Depends on dhc_pkg for the payload types.

// Pixel transaction: one RGB pixel
interface dhc_req_if;
   logic                 valid;
   logic                 ready;
   dhc_pkg::channel_type red;
   dhc_pkg::channel_type green;
   dhc_pkg::channel_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result transaction: one per pixel
interface dhc_rsp_if;
   logic               valid;
   logic               ready;
   logic               hash_bit;
   logic               bit_valid;
   logic               image_done;
   dhc_pkg::count_type distance;

   modport source (output valid, output hash_bit, output bit_valid, output image_done,
                   output distance, input ready);
   modport sink   (input valid, input hash_bit, input bit_valid, input image_done,
                   input distance, output ready);
endinterface

// Configuration write: compare_mode register
interface dhc_csr_if;
   logic valid;
   logic ready;
   logic compare_mode;

   modport source (output valid, output compare_mode, input ready);
   modport sink   (input valid, input compare_mode, output ready);
endinterface

### rtl/core/difference_image_hash_compare_core.sv
// Difference hash (dHash) engine with reference compare, single registered pass.
// Depends on dhc_pkg and the channel interfaces in dhc_channels.sv.
//
//   channel | role   | payload                                        | transaction
//   --------+--------+------------------------------------------------+-----------------
//   req     | sink   | red, green, blue (16 b each)                   | one pixel
//   rsp     | source | hash_bit, bit_valid, image_done, distance (7b) | one result/pixel
//   csr     | sink   | compare_mode (1 b)                             | register write
//
// rsp.valid is set the cycle after req accept; one pixel per cycle while rsp is ready.
// The luma multiply-add, the neighbor compare and the check against the registered
// reference bit all sit between the request handshake and the result register; the
// reference bit for the next hash position is prefetched from memory into a register.
// Reset (synchronous) clears the row/bit counters, luma, mismatch count and mode; the
// reference memory is not cleared, and req and csr are not ready while reset is high.
// A stalled rsp holds req only when the result register is full and rsp.ready is low.
module difference_image_hash_compare_core #(
   parameter int HASH_SIDE = dhc_pkg::HASH_SIDE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dhc_req_if.sink   req,
   dhc_rsp_if.source rsp,
   dhc_csr_if.sink   csr
);
   import dhc_pkg::*;

   localparam int ROW_PIXELS = HASH_SIDE + 1;
   localparam int HASH_BITS  = HASH_SIDE * HASH_SIDE;
   localparam int COL_W      = $clog2(ROW_PIXELS);
   localparam int IDX_W      = $clog2(HASH_BITS);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_PIXELS - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HASH_BITS - 1);

   logic             compare_mode_ff;
   logic [COL_W-1:0] column_count_ff, column_count_in;
   logic [IDX_W-1:0] bit_index_ff, bit_index_in;
   luma_type         previous_luma_ff, previous_luma_in;
   count_type        mismatch_count_ff, mismatch_count_in;
   logic             ref_bit_ff;
   logic             ref_mem [HASH_BITS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic             hash_bit_ff, hash_bit_in;
   logic             bit_valid_ff, bit_valid_in;
   logic             image_done_ff, image_done_in;
   count_type        distance_ff, distance_in;

   logic             req_take;
   luma_type         luma;
   logic             store_bit;

   // Accept while the result register is empty or draining
   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign req_take  = req.valid && req.ready;
   assign csr.ready = !reset;

   // Weighted luma, exact in 24 bits
   assign luma = luma_type'(req.red)   * WEIGHT_RED
               + luma_type'(req.green) * WEIGHT_GREEN
               + luma_type'(req.blue)  * WEIGHT_BLUE;

   // Hash bit, mismatch and position update for the current pixel
   always_comb begin
      hash_bit_in       = 1'b0;
      bit_valid_in      = 1'b0;
      image_done_in     = 1'b0;
      distance_in       = '0;
      mismatch_count_in = mismatch_count_ff;
      column_count_in   = column_count_ff;
      bit_index_in      = bit_index_ff;
      previous_luma_in  = previous_luma_ff;
      store_bit         = 1'b0;

      if (column_count_ff != '0) begin
         bit_valid_in = 1'b1;
         hash_bit_in  = (luma > previous_luma_ff);
         if (compare_mode_ff) begin
            if ((ref_bit_ff != hash_bit_in) && (mismatch_count_ff != COUNT_MAX)) begin
               mismatch_count_in = mismatch_count_ff + count_type'(1);
            end
         end else begin
            store_bit = 1'b1;
         end
         if ((bit_index_ff == IDX_LAST) && (column_count_ff == COL_LAST)) begin
            image_done_in = 1'b1;
            distance_in   = compare_mode_ff ? mismatch_count_in : '0;
         end
      end

      if (req_take) begin
         previous_luma_in = luma;
         if (image_done_in) begin
            column_count_in   = '0;
            bit_index_in      = '0;
            mismatch_count_in = '0;
         end else begin
            if (bit_valid_in) begin
               bit_index_in = (bit_index_ff == IDX_LAST) ? '0 : bit_index_ff + IDX_W'(1);
            end
            column_count_in = (column_count_ff == COL_LAST) ? '0
                                                             : column_count_ff + COL_W'(1);
         end
      end else begin
         mismatch_count_in = mismatch_count_ff;
      end
   end

   // Result register: load on accept, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         compare_mode_ff   <= 1'b0;
         column_count_ff   <= '0;
         bit_index_ff      <= '0;
         previous_luma_ff  <= '0;
         mismatch_count_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr.valid) begin
            compare_mode_ff <= csr.compare_mode;
         end
         column_count_ff   <= column_count_in;
         bit_index_ff      <= bit_index_in;
         previous_luma_ff  <= previous_luma_in;
         mismatch_count_ff <= mismatch_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload: hold until the next accepted transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         hash_bit_ff   <= hash_bit_in;
         bit_valid_ff  <= bit_valid_in;
         image_done_ff <= image_done_in;
         distance_ff   <= distance_in;
      end
   end

   // Reference memory: write in reference mode, prefetch the bit for the next position
   always_ff @(posedge clock) begin
      if (req_take && store_bit) begin
         ref_mem[bit_index_ff] <= hash_bit_in;
      end
      ref_bit_ff <= ref_mem[bit_index_in];
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hash_bit   = hash_bit_ff;
   assign rsp.bit_valid  = bit_valid_ff;
   assign rsp.image_done = image_done_ff;
   assign rsp.distance   = distance_ff;

   // Checks
   a_done_has_bit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.image_done |-> rsp.bit_valid)
      else $error("image_done without a hash bit");

   a_distance_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.image_done |-> rsp.distance == '0)
      else $error("nonzero distance before end of image");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      column_count_ff <= COL_LAST)
      else $error("column count out of range");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= IDX_LAST)
      else $error("bit index out of range");

   a_restart_after_done: assert property (@(posedge clock) disable iff (reset)
      req_take && image_done_in |=>
         column_count_ff == '0 && bit_index_ff == '0 && mismatch_count_ff == '0)
      else $error("counters not cleared after end of image");

endmodule

### tb/dhc_checker.sv
// Scoreboard for the difference-image hash compare core: watches the pixel, result and
// mode-write channels, predicts every result and compares it with what the core returns.
// Depends on dhc_pkg and the channel interfaces in dhc_channels.sv.
module dhc_checker #(
   parameter int SIDE = 8
) (
   input  logic clock,
   input  logic reset,
   dhc_req_if   req_ch,
   dhc_rsp_if   rsp_ch,
   dhc_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);
   import dhc_pkg::*;

   localparam int ROW_LEN   = SIDE + 1;
   localparam int BIT_COUNT = SIDE * SIDE;

   // Luma weights, 8 fraction bits
   localparam luma_type LUMA_W_RED   = 24'd54;
   localparam luma_type LUMA_W_GREEN = 24'd184;
   localparam luma_type LUMA_W_BLUE  = 24'd18;
   localparam count_type MISMATCH_CAP = 7'd127;

   typedef struct packed {
      logic      hash_bit;
      logic      bit_valid;
      logic      image_done;
      count_type distance;
   } hash_result_type;

   hash_result_type pending_hash_results[$];

   // Shadow of the core state
   logic      compare_enabled;
   int        column;
   int        bit_pos;
   luma_type  last_luma;
   count_type mismatches;
   logic      stored_hash[BIT_COUNT];
   int        failures;

   // Advance the shadow state by one pixel and return the result it must produce
   function automatic hash_result_type next_hash_result(channel_type r, channel_type g,
                                                        channel_type b);
      luma_type        luma;
      hash_result_type res;
      luma = LUMA_W_RED * r + LUMA_W_GREEN * g + LUMA_W_BLUE * b;
      res  = '0;
      if (column != 0) begin
         res.bit_valid = 1'b1;
         res.hash_bit  = (luma > last_luma);
         if (compare_enabled) begin
            if (stored_hash[bit_pos] != res.hash_bit && mismatches != MISMATCH_CAP)
               mismatches = mismatches + 1'b1;
         end else begin
            stored_hash[bit_pos] = res.hash_bit;
         end
         if (bit_pos == BIT_COUNT - 1 && column >= ROW_LEN - 1) begin
            res.image_done = 1'b1;
            res.distance   = compare_enabled ? mismatches : '0;
         end
      end
      last_luma = luma;
      if (res.image_done) begin
         column     = 0;
         bit_pos    = 0;
         mismatches = '0;
      end else begin
         if (res.bit_valid)
            bit_pos = (bit_pos + 1) % BIT_COUNT;
         column = column + 1;
         if (column >= ROW_LEN)
            column = 0;
      end
      return res;
   endfunction

   // Count a failure; report only the first few
   function automatic void note_failure(string msg);
      if (failures < 10)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      failures++;
   endfunction

   // Compare results first, then predict new pixels, then apply mode writes
   always @(posedge clock) begin
      hash_result_type want;
      hash_result_type got;
      hash_result_type predicted;
      if (reset) begin
         pending_hash_results.delete();
         compare_enabled = 1'b0;
         column          = 0;
         bit_pos         = 0;
         last_luma       = '0;
         mismatches      = '0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.hash_bit, rsp_ch.bit_valid, rsp_ch.image_done, rsp_ch.distance};
            if (pending_hash_results.size() == 0) begin
               note_failure($sformatf(
                  {"unexpected result hash_bit=%0b bit_valid=%0b ",
                   "image_done=%0b distance=%0d"},
                  got.hash_bit, got.bit_valid, got.image_done, got.distance));
            end else begin
               want = pending_hash_results.pop_front();
               if (got.hash_bit !== want.hash_bit || got.bit_valid !== want.bit_valid ||
                   got.image_done !== want.image_done || got.distance !== want.distance)
                  note_failure($sformatf(
                     {"expected hash_bit=%0b bit_valid=%0b image_done=%0b distance=%0d, ",
                      "got hash_bit=%0b bit_valid=%0b image_done=%0b distance=%0d"},
                     want.hash_bit, want.bit_valid, want.image_done, want.distance,
                     got.hash_bit, got.bit_valid, got.image_done, got.distance));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted = next_hash_result(req_ch.red, req_ch.green, req_ch.blue);
            pending_hash_results.insert(pending_hash_results.size(), predicted);
         end
         if (csr_ch.valid && csr_ch.ready)
            compare_enabled = csr_ch.compare_mode;
      end
      pending    <= pending_hash_results.size();
      fail_count <= failures;
   end

endmodule

### tb/tb_top.sv
// Top of the difference-image hash compare testbench: clock, reset, pixel stimulus,
// mode writes and the final verdict. Depends on dhc_pkg, dhc_channels.sv, the core
// and dhc_checker, which does all prediction and comparison.
module tb_top;
   import dhc_pkg::*;

   localparam int SIDE         = 8;
   localparam int ROW_LEN      = SIDE + 1;
   localparam int IMAGE_PIXELS = ROW_LEN * SIDE;
   localparam int PIXEL_TARGET = 700;

   typedef enum int {STYLE_NOISE, STYLE_RISING, STYLE_FALLING, STYLE_FLAT} image_style_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   dhc_req_if req_ch ();
   dhc_rsp_if rsp_ch ();
   dhc_csr_if csr_ch ();

   // Stimulus bookkeeping
   int              sent;
   int              pixel_pos;
   int              sender_idle_pct;
   int              receiver_idle_pct;
   image_style_type style;
   int              ramp_base;
   int              ramp_step;
   channel_type     flat_red, flat_green, flat_blue;

   difference_image_hash_compare_core #(
      .HASH_SIDE(SIDE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   dhc_checker #(
      .SIDE(SIDE)
   ) hash_monitor (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_ch    (csr_ch),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the core hangs
   initial begin
      #(20 * 500000);
      $display("difference_image_hash_compare_core test failed");
      $finish;
   end

   // Result side: random back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Offer one pixel, with random gaps first; hold valid until accepted
   task automatic send_pixel(input channel_type r, input channel_type g, input channel_type b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.red   <= r;
      req_ch.green <= g;
      req_ch.blue  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
      pixel_pos = (pixel_pos + 1) % IMAGE_PIXELS;
      // Swap idle rates after a third, drop idling after two thirds
      if (sent >= 2 * PIXEL_TARGET / 3) begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end else if (sent >= PIXEL_TARGET / 3) begin
         sender_idle_pct   = 54;
         receiver_idle_pct = 38;
      end
   endtask

   // Pick an image style at each image start, then build the pixel from it
   task automatic send_random_pixel();
      int          col;
      channel_type v;
      col = pixel_pos % ROW_LEN;
      if (pixel_pos == 0) begin
         case ($urandom_range(9))
            0, 1, 2, 3: style = STYLE_NOISE;
            4, 5, 6:    style = STYLE_RISING;
            7, 8:       style = STYLE_FALLING;
            default:    style = STYLE_FLAT;
         endcase
         ramp_step  = $urandom_range(1, 7000);
         ramp_base  = $urandom_range(0, 65535 - (ROW_LEN - 1) * ramp_step);
         flat_red   = channel_type'($urandom);
         flat_green = channel_type'($urandom);
         flat_blue  = channel_type'($urandom);
      end
      case (style)
         STYLE_RISING: begin
            v = channel_type'(ramp_base + col * ramp_step);
            send_pixel(v, v, v);
         end
         STYLE_FALLING: begin
            v = channel_type'(ramp_base + (ROW_LEN - 1 - col) * ramp_step);
            send_pixel(v, v, v);
         end
         STYLE_FLAT: send_pixel(flat_red, flat_green, flat_blue);
         default:    send_pixel(channel_type'($urandom), channel_type'($urandom),
                                channel_type'($urandom));
      endcase
   endtask

   // Write the mode register once the core has drained
   task automatic write_compare_mode(input logic mode);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.compare_mode <= mode;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      logic mode;
      int   phase;
      int   len;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.red          <= '0;
      req_ch.green        <= '0;
      req_ch.blue         <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.compare_mode <= 1'b0;
      sender_idle_pct   = 38;
      receiver_idle_pct = 54;
      sent      = 0;
      pixel_pos = 0;
      style     = STYLE_NOISE;
      mode      = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reference mode: channel extremes, equal lumas, first-of-row pixels
      write_compare_mode(1'b0);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'hFFFF);
      send_pixel(16'h0001, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'h0003);
      send_pixel(16'h0000, 16'h0000, 16'h0004);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
      send_pixel(16'h5555, 16'hAAAA, 16'h5555);
      send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'h0000, 16'h0001);
      send_pixel(16'h0000, 16'h0001, 16'h0000);
      send_pixel(16'h0001, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
      send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
      send_pixel(16'h8000, 16'h8000, 16'h8000);
      send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);

      // Fill the whole reference before any compare
      while (sent < 2 * IMAGE_PIXELS) send_random_pixel();
      req_ch.valid <= 1'b0;

      // Phases in random modes, compare first, mostly whole images, some cut mid-image
      phase = 0;
      while (sent < PIXEL_TARGET) begin
         mode = (phase == 0) ? 1'b1 : logic'($urandom_range(1));
         write_compare_mode(mode);
         if ($urandom_range(3) != 0)
            len = IMAGE_PIXELS - pixel_pos + IMAGE_PIXELS * $urandom_range(1);
         else
            len = $urandom_range(1, 100);
         // Stop at the item budget
         if (len > PIXEL_TARGET - sent)
            len = PIXEL_TARGET - sent;
         repeat (len) send_random_pixel();
         req_ch.valid <= 1'b0;
         phase++;
      end

      // Drain, then give the verdict
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("difference_image_hash_compare_core test passed");
      else
         $display("difference_image_hash_compare_core test failed");
      $finish;
   end

endmodule
